### rtl/idf_pkg.sv
// shared types and constants for the ipv4 df rewrite and checksum block
// no dependencies; imported by every module of the block
package idf_pkg;

    // store geometry
    localparam int STORE_DEPTH = 37;
    localparam int IDX_W       = 6;
    localparam int SUM_W       = 21;
    localparam int IHL_W       = 4;

    // word positions within the frame
    localparam logic [IDX_W-1:0] ETH_TYPE_IDX = 6'd6;
    localparam logic [IDX_W-1:0] IP_FIRST_IDX = 6'd7;
    localparam logic [IDX_W-1:0] FRAG_IDX     = 6'd10;
    localparam logic [IDX_W-1:0] PROTO_IDX    = 6'd11;
    localparam logic [IDX_W-1:0] CSUM_IDX     = 6'd12;

    // header values
    localparam logic [15:0]      IPV4_TYPE  = 16'h0800;
    localparam logic [15:0]      DF_WORD    = 16'h4000;
    localparam logic [3:0]       IP_VERSION = 4'd4;
    localparam logic [IHL_W-1:0] MIN_IHL    = 4'd5;
    localparam logic [7:0]       PROTO_TCP  = 8'd6;
    localparam logic [7:0]       PROTO_UDP  = 8'd17;

    // byte counts
    localparam logic [1:0] BYTES_ONE  = 2'd1;
    localparam logic [1:0] BYTES_FULL = 2'd2;

    typedef enum logic {
        FM_HOLD,
        FM_PASS
    } t_front_mode;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_FETCH,
        BS_LOAD
    } t_back_state;

    // command between front and back
    typedef struct packed {
        logic             is_flush;
        logic [15:0]      word;
        logic [IDX_W-1:0] count;
        logic [1:0]       nb;
        logic             last;
        logic             rewrite;
        logic [SUM_W-1:0] sum;
    } t_cmd;

    // header store write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [15:0]      data;
    } t_mem_wr;

endpackage

### rtl/idf_front.sv
// front part: accepts frame words, holds header bookkeeping, classifies frames
// depends on idf_pkg; feeds idf_queue with commands and idf_back with store writes
module idf_front
    import idf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_frame_word,
    input  logic [1:0]  i_word_bytes,
    input  logic        i_frame_end,
    input  logic        i_q_full,
    input  logic        i_flush_done,
    output logic        o_push,
    output t_cmd        o_cmd,
    output t_mem_wr     o_mem_wr
);

    t_front_mode      r_mode, n_mode;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IHL_W-1:0] r_hdr, n_hdr;
    logic             r_qual, n_qual;
    logic             r_proto_ok, n_proto_ok;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_busy, n_busy;

    logic             accept;
    logic [1:0]       nb;
    logic             nb_one;
    logic             ver_ok;
    logic [IHL_W-1:0] ihl;
    logic [IHL_W-1:0] hdr_eff;
    logic             qual_eff;
    logic [IDX_W-1:0] last_idx;
    logic [15:0]      add;
    logic [SUM_W-1:0] sum_next;
    logic             final_hdr;
    logic             flush;

    // hold mode waits for the back part to drain the store
    assign o_in_stall = i_q_full || (r_mode == FM_HOLD && r_busy);
    assign accept     = i_in_valid && !o_in_stall;

    assign nb_one   = (i_word_bytes == BYTES_ONE);
    assign nb       = nb_one ? BYTES_ONE : BYTES_FULL;
    assign ihl      = i_frame_word[11:8];
    assign ver_ok   = (i_frame_word[15:12] == IP_VERSION) && (ihl >= MIN_IHL);
    assign hdr_eff  = (r_idx == IP_FIRST_IDX) ? ihl : r_hdr;
    assign qual_eff = (r_idx == IP_FIRST_IDX) ? ver_ok : r_qual;
    assign last_idx = ETH_TYPE_IDX + {1'b0, hdr_eff, 1'b0};

    // running header sum with fragment word forced and checksum zeroed
    always_comb begin
        if (r_idx == FRAG_IDX) begin
            add = DF_WORD;
        end else if (r_idx == CSUM_IDX) begin
            add = 16'h0000;
        end else begin
            add = i_frame_word;
        end
    end
    assign sum_next = r_sum + SUM_W'(add);

    assign final_hdr = qual_eff && (r_idx >= IP_FIRST_IDX) && (r_idx == last_idx);

    assign flush = nb_one
                || (r_idx == ETH_TYPE_IDX && i_frame_word != IPV4_TYPE)
                || (r_idx == IP_FIRST_IDX && !ver_ok)
                || final_hdr
                || i_frame_end;

    // store write for every held word
    always_comb begin
        o_mem_wr.en   = accept && (r_mode == FM_HOLD);
        o_mem_wr.addr = r_idx;
        o_mem_wr.data = i_frame_word;
    end

    // next state and command
    always_comb begin
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_hdr      = r_hdr;
        n_qual     = r_qual;
        n_proto_ok = r_proto_ok;
        n_sum      = r_sum;
        n_busy     = r_busy && !i_flush_done;
        o_push     = 1'b0;

        o_cmd.is_flush = 1'b0;
        o_cmd.word     = i_frame_word;
        o_cmd.count    = r_idx + 6'd1;
        o_cmd.nb       = nb;
        o_cmd.last     = i_frame_end;
        o_cmd.rewrite  = !nb_one && final_hdr && r_proto_ok;
        o_cmd.sum      = sum_next;

        if (accept) begin
            if (r_mode == FM_PASS) begin
                o_push = 1'b1;
                if (i_frame_end) begin
                    n_mode = FM_HOLD;
                end
            end else begin
                n_idx = r_idx + 6'd1;
                if (r_idx == IP_FIRST_IDX) begin
                    n_hdr  = ihl;
                    n_qual = ver_ok;
                end
                if (r_idx == PROTO_IDX) begin
                    n_proto_ok = (i_frame_word[7:0] == PROTO_TCP)
                              || (i_frame_word[7:0] == PROTO_UDP);
                end
                if (qual_eff && r_idx >= IP_FIRST_IDX) begin
                    n_sum = sum_next;
                end
                if (flush) begin
                    o_push         = 1'b1;
                    o_cmd.is_flush = 1'b1;
                    n_busy         = 1'b1;
                    n_idx          = '0;
                    n_hdr          = '0;
                    n_qual         = 1'b0;
                    n_proto_ok     = 1'b0;
                    n_sum          = '0;
                    n_mode         = i_frame_end ? FM_HOLD : FM_PASS;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= FM_HOLD;
            r_idx      <= '0;
            r_hdr      <= '0;
            r_qual     <= 1'b0;
            r_proto_ok <= 1'b0;
            r_sum      <= '0;
            r_busy     <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_idx      <= n_idx;
            r_hdr      <= n_hdr;
            r_qual     <= n_qual;
            r_proto_ok <= n_proto_ok;
            r_sum      <= n_sum;
            r_busy     <= n_busy;
        end
    end

endmodule

### rtl/idf_queue.sv
// two-entry command queue between front and back parts
// depends on idf_pkg for the command type
module idf_queue
    import idf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/idf_back.sv
// back part: header store, flush sequencer and output register
// depends on idf_pkg; takes commands from idf_queue and store writes from idf_front
module idf_back
    import idf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_wr     i_mem_wr,
    input  t_cmd        i_head,
    input  logic        i_q_empty,
    output logic        o_pop,
    output logic        o_flush_done,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_word,
    output logic [1:0]  o_out_bytes,
    output logic        o_out_end
);

    logic [15:0]      r_mem [STORE_DEPTH];
    logic [15:0]      r_rd_data;
    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [IDX_W-1:0] r_k, n_k;
    logic [16:0]      r_fold, n_fold;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_word, n_out_word;
    logic [1:0]       r_out_bytes, n_out_bytes;
    logic             r_out_end, n_out_end;

    logic             out_free;
    logic             is_last;
    logic [15:0]      csum;
    logic [15:0]      held_word;

    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = (r_k == r_cmd.count - 6'd1);
    assign csum     = ~(r_fold[15:0] + 16'(r_fold[16]));

    // substitute the rewritten fragment and checksum words
    always_comb begin
        if (r_cmd.rewrite && r_k == FRAG_IDX) begin
            held_word = DF_WORD;
        end else if (r_cmd.rewrite && r_k == CSUM_IDX) begin
            held_word = csum;
        end else begin
            held_word = r_rd_data;
        end
    end

    // header store
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[r_k];
    end

    // sequencer and output register next values
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_k          = r_k;
        n_fold       = r_fold;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;
        n_out_bytes  = r_out_bytes;
        n_out_end    = r_out_end;
        o_pop        = 1'b0;
        o_flush_done = 1'b0;

        case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    if (i_head.is_flush) begin
                        o_pop   = 1'b1;
                        n_cmd   = i_head;
                        n_k     = '0;
                        n_fold  = 17'(i_head.sum[15:0]) + 17'(i_head.sum[SUM_W-1:16]);
                        n_state = BS_FETCH;
                    end else if (out_free) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_word  = i_head.word;
                        n_out_bytes = i_head.nb;
                        n_out_end   = i_head.last;
                    end
                end
            end
            BS_FETCH: begin
                n_state = BS_LOAD;
            end
            BS_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = held_word;
                    n_out_bytes = is_last ? r_cmd.nb : BYTES_FULL;
                    n_out_end   = is_last ? r_cmd.last : 1'b0;
                    if (is_last) begin
                        o_flush_done = 1'b1;
                        n_state      = BS_IDLE;
                    end else begin
                        n_k     = r_k + 6'd1;
                        n_state = BS_FETCH;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_fold      <= n_fold;
        r_out_word  <= n_out_word;
        r_out_bytes <= n_out_bytes;
        r_out_end   <= n_out_end;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_out_bytes = r_out_bytes;
    assign o_out_end   = r_out_end;

endmodule

### rtl/ipv4_df_rewrite_checksum.sv
// ipv4 df rewrite with header checksum regeneration, top level
// header words are taken one per cycle and pass-through words one per cycle, while o_in_stall is low
// a held header drains word by word (store read in the fetch state, then output register in the
// load state), and new header words wait until the drain finishes
// the first output of a closed header passes the command queue, the fetch and load states and the output register
// reset: synchronous, active low; clears control state, header store is not cleared
module ipv4_df_rewrite_checksum
    import idf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_frame_word,
    input  logic [1:0]  i_word_bytes,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_word,
    output logic [1:0]  o_out_bytes,
    output logic        o_out_end
);

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    logic    flush_done;
    t_cmd    cmd;
    t_cmd    head;
    t_mem_wr mem_wr;

    // classification and header bookkeeping
    idf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frame_word (i_frame_word),
        .i_word_bytes (i_word_bytes),
        .i_frame_end  (i_frame_end),
        .i_q_full     (q_full),
        .i_flush_done (flush_done),
        .o_push       (push),
        .o_cmd        (cmd),
        .o_mem_wr     (mem_wr)
    );

    // command queue
    idf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // store, flush sequencing and output
    idf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mem_wr     (mem_wr),
        .i_head       (head),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_flush_done (flush_done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word),
        .o_out_bytes  (o_out_bytes),
        .o_out_end    (o_out_end)
    );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// testbench for ipv4_df_rewrite_checksum: directed and random ethernet frames, scoreboard check
// depends on idf_pkg and the block's rtl only; self-contained, no files or arguments
module tb
    import idf_pkg::*;
();

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          PHASE_WORDS   = 60;
    localparam int          DRAIN_CYCLES  = 40;
    // word_bytes codes outside 1 and 2, both read as a full word
    localparam logic [1:0]  BYTES_CODE_Z  = 2'd0;
    localparam logic [1:0]  BYTES_CODE_3  = 2'd3;

    typedef struct {
        logic [15:0] word;
        logic [1:0]  bytes;
        logic        is_last;
    } t_frame_word;

    typedef enum {
        FK_TCP_UDP,
        FK_OTHER_PROTO,
        FK_BAD_IP,
        FK_WRONG_TYPE,
        FK_RUNT,
        FK_ODD_BYTE
    } t_frame_kind;

    // expected output words, predicted from every accepted input transaction
    class frame_rewrite_sb;
        t_frame_word       expected_words[$];
        logic [15:0]       held_words[STORE_DEPTH];
        int                held_count;
        t_front_mode       mode;
        int                ip_ihl;
        bit                ip_ok;
        logic [SUM_W-1:0]  hdr_sum;
        int                errors;

        function new();
            errors = 0;
            start_frame();
        endfunction

        function void start_frame();
            held_count = 0;
            mode       = FM_HOLD;
            ip_ihl     = 0;
            ip_ok      = 1'b0;
            hdr_sum    = '0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push_word(logic [15:0] w, logic [1:0] nb, logic is_last);
            t_frame_word item;
            item.word    = w;
            item.bytes   = nb;
            item.is_last = is_last;
            expected_words.push_back(item);
        endfunction

        // emit every held word; the last one carries the current bytes and end
        function void release_held(logic [1:0] nb, logic is_last);
            for (int k = 0; k < held_count; k++) begin
                if (k == held_count - 1)
                    push_word(held_words[k], nb, is_last);
                else
                    push_word(held_words[k], BYTES_FULL, 1'b0);
            end
            if (is_last) begin
                start_frame();
            end else begin
                held_count = 0;
                mode       = FM_PASS;
            end
        endfunction

        function void note_input(logic [15:0] w, logic [1:0] code, logic is_last);
            logic [1:0]       nb;
            int               idx;
            logic [15:0]      addend;
            logic [SUM_W-1:0] s;
            logic [7:0]       proto;
            nb = (code == BYTES_ONE) ? BYTES_ONE : BYTES_FULL;

            // pass-through of the frame body
            if (mode != FM_HOLD) begin
                push_word(w, nb, is_last);
                if (is_last)
                    start_frame();
                return;
            end
            if (held_count >= STORE_DEPTH) begin
                release_held(nb, is_last);
                return;
            end

            idx = held_count;
            held_words[idx] = w;
            held_count = idx + 1;

            if (nb == BYTES_ONE) begin
                release_held(nb, is_last);
                return;
            end
            if (idx == int'(ETH_TYPE_IDX) && w != IPV4_TYPE) begin
                release_held(nb, is_last);
                return;
            end
            if (idx == int'(IP_FIRST_IDX)) begin
                ip_ihl = int'(w[11:8]);
                if (w[15:12] != IP_VERSION || w[11:8] < MIN_IHL) begin
                    release_held(nb, is_last);
                    return;
                end
                ip_ok = 1'b1;
            end

            // running header sum, fragment word taken as df and checksum as zero
            if (idx >= int'(IP_FIRST_IDX) && ip_ok) begin
                if (idx == int'(FRAG_IDX))
                    addend = DF_WORD;
                else if (idx == int'(CSUM_IDX))
                    addend = 16'h0000;
                else
                    addend = w;
                hdr_sum = hdr_sum + SUM_W'(addend);
                if (idx == int'(IP_FIRST_IDX) - 1 + 2 * ip_ihl) begin
                    proto = held_words[PROTO_IDX][7:0];
                    if (proto == PROTO_TCP || proto == PROTO_UDP) begin
                        s = hdr_sum;
                        s = {5'b0, s[15:0]} + {16'b0, s[20:16]};
                        s = {5'b0, s[15:0]} + {16'b0, s[20:16]};
                        held_words[FRAG_IDX] = DF_WORD;
                        held_words[CSUM_IDX] = ~s[15:0];
                    end
                    release_held(nb, is_last);
                    return;
                end
            end

            if (is_last)
                release_held(nb, is_last);
        endfunction

        task check_result(logic [15:0] w, logic [1:0] nb, logic is_last);
            t_frame_word exp_word;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h bytes %0d end %0b", w, nb, is_last));
                return;
            end
            exp_word = expected_words.pop_front();
            if (w !== exp_word.word || nb !== exp_word.bytes || is_last !== exp_word.is_last)
                report($sformatf("word %h bytes %0d end %0b, expected %h bytes %0d end %0b",
                                 w, nb, is_last,
                                 exp_word.word, exp_word.bytes, exp_word.is_last));
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_frame_word = '0;
    logic [1:0]  i_word_bytes = BYTES_FULL;
    logic        i_frame_end  = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [15:0] o_out_word;
    logic [1:0]  o_out_bytes;
    logic        o_out_end;

    int              in_idle_pct   = 0;
    int              out_stall_pct = 0;
    int              cycle_count   = 0;
    t_frame_word     frame_q[$];
    frame_rewrite_sb sb = new();

    ipv4_df_rewrite_checksum dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frame_word (i_frame_word),
        .i_word_bytes (i_word_bytes),
        .i_frame_end  (i_frame_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word),
        .o_out_bytes  (o_out_bytes),
        .o_out_end    (o_out_end)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // random back-pressure on the output side
    always @(posedge i_clk) begin
        i_out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    end

    // watch both channels; values read here are the ones before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(i_frame_word, i_word_bytes, i_frame_end);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_word, o_out_bytes, o_out_end);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [1:0] full_code();
        case ($urandom_range(7))
            0:       return BYTES_CODE_Z;
            1:       return BYTES_CODE_3;
            default: return BYTES_FULL;
        endcase
    endfunction

    function automatic void add_word(logic [15:0] w, logic [1:0] code, logic is_last);
        t_frame_word item;
        item.word    = w;
        item.bytes   = code;
        item.is_last = is_last;
        frame_q.push_back(item);
    endfunction

    // one ethernet frame of the given kind into frame_q; ihl_force > 0 fixes the ihl
    function automatic void build_frame(t_frame_kind kind, int ihl_force);
        logic [15:0] w;
        logic [3:0]  ver;
        logic [7:0]  proto;
        logic [1:0]  code;
        int          ihl, hdr_len, n, odd_at, r;
        ver   = IP_VERSION;
        proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        r     = $urandom_range(19);
        if (ihl_force > 0)
            ihl = ihl_force;
        else if (r == 0)
            ihl = 15;
        else if (r < 4)
            ihl = $urandom_range(14, 6);
        else
            ihl = 5;
        case (kind)
            FK_OTHER_PROTO: begin
                do proto = 8'($urandom); while (proto == PROTO_TCP || proto == PROTO_UDP);
            end
            FK_BAD_IP: begin
                if ($urandom_range(1))
                    ihl = $urandom_range(4);
                else
                    do ver = 4'($urandom); while (ver == IP_VERSION);
            end
            default: ;
        endcase
        hdr_len = 7 + 2 * ihl;
        n = ((hdr_len < 8) ? 8 : hdr_len) + $urandom_range(4);
        odd_at = -1;
        if (kind == FK_RUNT)
            n = $urandom_range(hdr_len, 1);
        if (kind == FK_ODD_BYTE) begin
            odd_at = $urandom_range(hdr_len - 1);
            if ($urandom_range(1))
                n = odd_at + 1;
        end

        for (int k = 0; k < n; k++) begin
            w = 16'($urandom);
            if (k == int'(ETH_TYPE_IDX)) begin
                if (kind != FK_WRONG_TYPE)
                    w = IPV4_TYPE;
                else if ($urandom_range(1))
                    w = {IPV4_TYPE[7:0], IPV4_TYPE[15:8]};
                else
                    while (w == IPV4_TYPE) w = 16'($urandom);
            end
            if (k == int'(IP_FIRST_IDX))
                w[15:8] = {ver, 4'(ihl)};
            if (k == int'(PROTO_IDX))
                w[7:0] = proto;
            code = full_code();
            if (k == odd_at)
                code = BYTES_ONE;
            else if (k == n - 1 && $urandom_range(2) == 0)
                code = BYTES_ONE;
            else if (k >= hdr_len && $urandom_range(19) == 0)
                code = BYTES_ONE;
            add_word(w, code, k == n - 1);
        end
    endfunction

    // drive one input transaction and wait until it is taken
    task automatic send_word(t_frame_word item);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_frame_word <= item.word;
        i_word_bytes <= item.bytes;
        i_frame_end  <= item.is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[k])
            send_word(frame_q[k]);
        frame_q.delete();
    endtask

    initial begin
        int          sent;
        int          frame_no;
        int          r;
        t_frame_kind kind;
        int          idle_in[4];
        int          stall_out[4];

        idle_in   = '{0, 83, 0, 35};
        stall_out = '{0, 0, 83, 35};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // runt of one word, odd byte code three
        add_word(16'hFFFF, BYTES_CODE_3, 1'b1);
        // runt ending on a one-byte word, with an unusual byte code
        add_word(16'h0000, BYTES_CODE_Z, 1'b0);
        add_word(16'hFFFF, BYTES_FULL, 1'b0);
        add_word(16'h1234, BYTES_ONE, 1'b1);
        // byte-swapped ethertype, then a pass-through word that ends the frame
        for (int k = 0; k < 6; k++)
            add_word((k % 2) ? 16'hFFFF : 16'h0000, BYTES_FULL, 1'b0);
        add_word({IPV4_TYPE[7:0], IPV4_TYPE[15:8]}, BYTES_FULL, 1'b0);
        add_word(16'hA5A5, BYTES_ONE, 1'b1);
        // ihl below minimum, flushed unmodified
        for (int k = 0; k < 6; k++)
            add_word(16'h5A5A, BYTES_FULL, 1'b0);
        add_word(IPV4_TYPE, BYTES_FULL, 1'b0);
        add_word({IP_VERSION, 4'(MIN_IHL - 1), 8'hFF}, BYTES_FULL, 1'b0);
        add_word(16'h8001, BYTES_FULL, 1'b1);
        send_frame();

        // random frames under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            in_idle_pct   = idle_in[phase];
            out_stall_pct = stall_out[phase];
            sent     = 0;
            frame_no = 0;
            while (sent < PHASE_WORDS) begin
                r = $urandom_range(99);
                if (r < 55)      kind = FK_TCP_UDP;
                else if (r < 65) kind = FK_OTHER_PROTO;
                else if (r < 73) kind = FK_BAD_IP;
                else if (r < 80) kind = FK_WRONG_TYPE;
                else if (r < 90) kind = FK_RUNT;
                else             kind = FK_ODD_BYTE;
                if (frame_no == 0)
                    build_frame(FK_TCP_UDP, (phase == 0) ? 15 : 5);
                else
                    build_frame(kind, 0);
                sent += frame_q.size();
                frame_no++;
                send_frame();
            end
        end
        i_in_valid <= 1'b0;

        // drain, then keep watching the output for anything stray
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/idf_pkg.sv
rtl/idf_front.sv
rtl/idf_queue.sv
rtl/idf_back.sv
rtl/ipv4_df_rewrite_checksum.sv
dv/tb.sv
